>>> src/bmhq_pkg.sv
// Shared types, codes and sizes of the binary min-heap queue unit.
package bmhq_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP_RD  = 8'b0000_0010,
        S_UP_CMP = 8'b0000_0100,
        S_POP_LD = 8'b0000_1000,
        S_PEEK   = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

endpackage

>>> src/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue in one memory with one write and two read ports.
// Refused or unused requests go straight to the result; peek reads the root, as does a pop
// that empties the queue; a push enters at the end and rises level by level, and any other
// pop puts the last entry at the root and sinks it level by level until it settles.
// Each level costs a memory read then a compare and write back; the next request is taken
// in the cycle after the result is loaded. Reset empties the queue; memory is not cleared.
module binary_min_heap_queue_unit #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [bmhq_pkg::OP_W-1:0]             i_operation,
    input  logic signed [bmhq_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [bmhq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [bmhq_pkg::VALUE_W-1:0]   o_result_value,
    output logic [bmhq_pkg::COUNT_W-1:0]          o_entry_count
);
    import bmhq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] heap_mem [CAPACITY];

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]             mem_ra;
    logic [AW-1:0]             mem_rb;
    logic signed [VALUE_W-1:0] r_rd_a;
    logic signed [VALUE_W-1:0] r_rd_b;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_pos, n_pos;
    logic [AW-1:0]             r_par, n_par;
    logic [AW-1:0]             r_lc, n_lc;
    logic                      r_rv, n_rv;
    logic signed [VALUE_W-1:0] r_key, n_key;
    logic signed [VALUE_W-1:0] r_res, n_res;
    t_status                   r_status, n_status;

    logic                      r_o_valid, n_o_valid;
    t_status                   r_o_status, n_o_status;
    logic signed [VALUE_W-1:0] r_o_value, n_o_value;
    logic [COUNT_W-1:0]        r_o_count, n_o_count;

    logic [CW-1:0]             cnt_m1;
    logic [CW:0]               child_l;
    logic [CW:0]               child_r;
    logic                      take_r;
    logic [AW-1:0]             sel_idx;
    logic signed [VALUE_W-1:0] sel_val;

    // Reads always target entries other than the one written in the same or the
    // previous cycle (children lie below, parents above), so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= heap_mem[mem_ra];
        r_rd_b <= heap_mem[mem_rb];
    end

    assign cnt_m1  = r_count - CW'(1);
    assign child_l = (CW+1)'({r_pos, 1'b1});
    assign child_r = child_l + (CW+1)'(1);
    assign take_r  = r_rv && (r_rd_b < r_rd_a);
    assign sel_idx = take_r ? (r_lc + AW'(1)) : r_lc;
    assign sel_val = take_r ? r_rd_b : r_rd_a;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_par      = r_par;
        n_lc       = r_lc;
        n_rv       = r_rv;
        n_key      = r_key;
        n_res      = r_res;
        n_status   = r_status;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        n_o_count  = r_o_count;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = r_key;
        mem_ra     = '0;
        mem_rb     = cnt_m1[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = ST_OK;
                    n_res    = '0;
                    case (t_op'(i_operation))
                        OP_PUSH: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_key   = i_value;
                                n_pos   = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                // Root on port a, last entry on port b.
                                n_count = cnt_m1;
                                n_state = S_POP_LD;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_PEEK;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_par   = (r_pos - AW'(1)) >> 1;
                    mem_ra  = (r_pos - AW'(1)) >> 1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_rd_a > r_key) begin
                    mem_wdata = r_rd_a;
                    n_pos     = r_par;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_POP_LD: begin
                n_res = r_rd_a;
                n_key = r_rd_b;
                n_pos = '0;
                n_state = (r_count == '0) ? S_RESP : S_DN_RD;
            end
            S_PEEK: begin
                n_res   = r_rd_a;
                n_state = S_RESP;
            end
            S_DN_RD: begin
                if (child_l >= (CW+1)'(r_count)) begin
                    mem_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    mem_ra  = child_l[AW-1:0];
                    mem_rb  = child_r[AW-1:0];
                    n_lc    = child_l[AW-1:0];
                    n_rv    = child_r < (CW+1)'(r_count);
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_key > sel_val) begin
                    mem_wdata = sel_val;
                    n_pos     = sel_idx;
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_value  = r_res;
                    n_o_count  = COUNT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_pos      <= n_pos;
        r_par      <= n_par;
        r_lc       <= n_lc;
        r_rv       <= n_rv;
        r_key      <= n_key;
        r_res      <= n_res;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_count  <= n_o_count;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_value = r_o_value;
    assign o_entry_count  = r_o_count;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the binary min-heap queue unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int HEAP_DEPTH   = CAPACITY_DEF;
    localparam int IDLE_PCT     = 27;
    localparam int ITEM_TARGET  = 1050;
    localparam int DRAIN_MIN    = 40;
    localparam int SETTLE       = 2 * $clog2(HEAP_DEPTH) + 12;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]         count;
    } t_heap_reply;

    // Tracks the queue contents and the replies still owed by the block.
    class t_heap_reply_board;
        logic signed [VALUE_W-1:0] keys [HEAP_DEPTH];
        int unsigned fill;
        int unsigned peak_fill;
        t_heap_reply expected_replies [$];
        int unsigned op_counts [4];
        int unsigned full_rejects;
        int unsigned empty_rejects;
        int unsigned replies_seen;
        int unsigned mismatches;

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        function void sift_in(logic signed [VALUE_W-1:0] key);
            int unsigned pos;
            int unsigned parent;
            pos = fill;
            fill++;
            // A rising key stops at a parent equal to it.
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (keys[parent] <= key)
                    break;
                keys[pos] = keys[parent];
                pos = parent;
            end
            keys[pos] = key;
        endfunction

        function logic signed [VALUE_W-1:0] take_min();
            logic signed [VALUE_W-1:0] top;
            logic signed [VALUE_W-1:0] last;
            int unsigned pos;
            int unsigned child;
            top = keys[0];
            fill--;
            last = keys[fill];
            pos = 0;
            // The right child wins only when strictly smaller than the left one.
            while (1) begin
                child = 2 * pos + 1;
                if (child >= fill)
                    break;
                if (child + 1 < fill && keys[child + 1] < keys[child])
                    child++;
                if (last <= keys[child])
                    break;
                keys[pos] = keys[child];
                pos = child;
            end
            if (fill > 0)
                keys[pos] = last;
            return top;
        endfunction

        function void note_request(t_op op, logic signed [VALUE_W-1:0] key);
            t_heap_reply want;
            want.status = ST_OK;
            want.value  = '0;
            op_counts[op]++;
            case (op)
                OP_PUSH: begin
                    if (fill >= HEAP_DEPTH) begin
                        want.status = ST_FULL;
                        full_rejects++;
                    end else begin
                        sift_in(key);
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (fill == 0) begin
                        want.status = ST_EMPTY;
                        empty_rejects++;
                    end else if (op == OP_POP) begin
                        want.value = take_min();
                    end else begin
                        want.value = keys[0];
                    end
                end
                default: ;
            endcase
            if (fill > peak_fill)
                peak_fill = fill;
            want.count = COUNT_W'(fill);
            expected_replies.push_back(want);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: %s", mismatches, what);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status,
                                  logic signed [VALUE_W-1:0] value,
                                  logic [COUNT_W-1:0] count);
            t_heap_reply want;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                report($sformatf("unexpected reply: status %0d value %0d count %0d",
                                 status, value, count));
                return;
            end
            want = expected_replies.pop_front();
            if (status !== want.status || value !== want.value || count !== want.count)
                report($sformatf({"reply %0d: expected status %0d value %0d count %0d,",
                                  " got status %0d value %0d count %0d"},
                                 replies_seen, want.status, want.value, want.count,
                                 status, value, count));
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [OP_W-1:0]               i_operation = OP_NONE;
    logic signed [VALUE_W-1:0]     i_value = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [STATUS_W-1:0]           o_status;
    logic signed [VALUE_W-1:0]     o_result_value;
    logic [COUNT_W-1:0]            o_entry_count;

    t_heap_reply_board board = new;
    bit              steady_run = 1'b0;
    int unsigned     sent_total = 0;

    binary_min_heap_queue_unit #(
        .CAPACITY (HEAP_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: stall at random except during the steady stretch.
    initial begin
        forever begin
            @(negedge i_clk);
            i_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_reply(o_status, o_result_value, o_entry_count);
    end

    initial begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("no handshake for %0d cycles, %0d replies outstanding",
                 STALL_LIMIT, board.pending());
        $display("FAIL");
        $finish;
    end

    function automatic t_op pick_op(int unsigned push_pct, int unsigned pop_pct,
                                    int unsigned peek_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            return OP_PUSH;
        if (roll < push_pct + pop_pct)
            return OP_POP;
        if (roll < push_pct + pop_pct + peek_pct)
            return OP_PEEK;
        return OP_NONE;
    endfunction

    // Full-range keys, keys near both extremes, and a share of small keys to force ties.
    function automatic logic signed [VALUE_W-1:0] pick_key();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return VALUE_W'(int'($urandom_range(8)) - 4);
            7:          return 32'sh7FFF_FFFF - $urandom_range(3);
            8:          return 32'sh8000_0000 + $urandom_range(3);
            default:    return $urandom_range(1) ? 32'sd0 : -32'sd1;
        endcase
    endfunction

    // Drives one request, waits for it to be taken, and leaves at a falling edge.
    task automatic issue(input t_op op, input logic signed [VALUE_W-1:0] key);
        steady_run = (sent_total >= 420 && sent_total < 580);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= key;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        board.note_request(op, key);
        sent_total++;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned random_items;
        int unsigned drain_start;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty queue, extremes of the key range, ties and the unused code.
        issue(OP_PEEK, 32'sh1234_5678);
        issue(OP_POP, -32'sd1);
        issue(OP_NONE, -32'sd1);
        issue(OP_PUSH, 32'sd0);
        issue(OP_PUSH, 32'sh7FFF_FFFF);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, 32'sd5);
        issue(OP_PUSH, 32'sd5);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PEEK, 32'sd0);
        repeat (4) issue(OP_POP, 32'sh7FFF_FFFF);
        issue(OP_NONE, 32'sh5555_AAAA);
        issue(OP_PUSH, 32'sd1);
        repeat (5) issue(OP_POP, 32'sh8000_0000);

        // Near-empty traffic, then a push-heavy climb until the queue refuses
        // several pushes, then pop-heavy traffic that sifts through a deep heap.
        random_items = 0;
        while (random_items < 24) begin
            issue(pick_op(45, 35, 15), pick_key());
            random_items++;
        end
        while (!(board.fill == HEAP_DEPTH && board.full_rejects >= 6)) begin
            issue(pick_op(99, 0, 1), pick_key());
            random_items++;
        end
        drain_start = random_items;
        while (sent_total < ITEM_TARGET || random_items < drain_start + DRAIN_MIN) begin
            issue(pick_op(15, 65, 15), pick_key());
            random_items++;
        end

        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d requests: %0d push, %0d pop, %0d peek, %0d unused; %0d replies.",
                 sent_total, board.op_counts[OP_PUSH], board.op_counts[OP_POP],
                 board.op_counts[OP_PEEK], board.op_counts[OP_NONE], board.replies_seen);
        $display("Peak fill %0d of %0d; %0d pushes refused full, %0d requests found it empty.",
                 board.peak_fill, HEAP_DEPTH, board.full_rejects, board.empty_rejects);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d replies missing", board.mismatches, board.pending());
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/bmhq_pkg.sv
src/binary_min_heap_queue_unit.sv
tb/testbench.sv
